/* design/ckd_pkg.sv */
// Shared key codes and the CSI suffix table for the console key sequence decoder.
package ckd_pkg;

  localparam int unsigned AVAIL_W   = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KEY_W     = 6;
  localparam int unsigned SUFFIX_COUNT = 46;
  localparam int unsigned MAX_AVAIL = 4;

  localparam logic [BYTE_W-1:0] CSI_BYTE   = 8'h9B;
  localparam logic [BYTE_W-1:0] CHR_CTRL_C = 8'h03;
  localparam logic [BYTE_W-1:0] CHR_CTRL_D = 8'h04;
  localparam logic [BYTE_W-1:0] CHR_CTRL_E = 8'h05;
  localparam logic [BYTE_W-1:0] CHR_CTRL_F = 8'h06;
  localparam logic [BYTE_W-1:0] CHR_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CHR_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_CTRL_X = 8'd24;
  localparam logic [BYTE_W-1:0] CHR_DEL    = 8'd127;

  localparam logic [KEY_W-1:0] KEY_DONE       = 6'd0;
  localparam logic [KEY_W-1:0] KEY_CTRL_C     = 6'd1;
  localparam logic [KEY_W-1:0] KEY_CTRL_D     = 6'd2;
  localparam logic [KEY_W-1:0] KEY_CTRL_E     = 6'd3;
  localparam logic [KEY_W-1:0] KEY_CTRL_F     = 6'd4;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE  = 6'd5;
  localparam logic [KEY_W-1:0] KEY_TAB        = 6'd6;
  localparam logic [KEY_W-1:0] KEY_LINEFEED   = 6'd7;
  localparam logic [KEY_W-1:0] KEY_RETURN     = 6'd8;
  localparam logic [KEY_W-1:0] KEY_DELETE     = 6'd9;
  localparam logic [KEY_W-1:0] KEY_CONTROL_X  = 6'd10;
  localparam logic [KEY_W-1:0] KEY_UNKNOWN    = 6'd11;
  localparam logic [KEY_W-1:0] KEY_STRING     = 6'd12;
  localparam logic [KEY_W-1:0] KEY_TABLE_BASE = 6'd13;

  typedef struct packed {
    logic [1:0]        len;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } suffix_t;

  localparam suffix_t SUFFIX_TABLE [SUFFIX_COUNT] = '{
    '{2'd1, "A", 8'h00, 8'h00}, '{2'd1, "B", 8'h00, 8'h00},
    '{2'd1, "C", 8'h00, 8'h00}, '{2'd1, "D", 8'h00, 8'h00},
    '{2'd1, "T", 8'h00, 8'h00}, '{2'd1, "S", 8'h00, 8'h00},
    '{2'd2, " ", "@", 8'h00},   '{2'd2, " ", "A", 8'h00},
    '{2'd1, "Z", 8'h00, 8'h00},
    '{2'd2, "?", "~", 8'h00},
    '{2'd2, "0", "~", 8'h00},   '{2'd2, "1", "~", 8'h00},
    '{2'd2, "2", "~", 8'h00},   '{2'd2, "3", "~", 8'h00},
    '{2'd2, "4", "~", 8'h00},   '{2'd2, "5", "~", 8'h00},
    '{2'd2, "6", "~", 8'h00},   '{2'd2, "7", "~", 8'h00},
    '{2'd2, "8", "~", 8'h00},   '{2'd2, "9", "~", 8'h00},
    '{2'd3, "2", "0", "~"},     '{2'd3, "2", "1", "~"},
    '{2'd3, "1", "0", "~"},     '{2'd3, "1", "1", "~"},
    '{2'd3, "1", "2", "~"},     '{2'd3, "1", "3", "~"},
    '{2'd3, "1", "4", "~"},     '{2'd3, "1", "5", "~"},
    '{2'd3, "1", "6", "~"},     '{2'd3, "1", "7", "~"},
    '{2'd3, "1", "8", "~"},     '{2'd3, "1", "9", "~"},
    '{2'd3, "3", "0", "~"},     '{2'd3, "3", "1", "~"},
    '{2'd3, "4", "0", "~"},     '{2'd3, "4", "1", "~"},
    '{2'd3, "4", "2", "~"},     '{2'd3, "4", "3", "~"},
    '{2'd3, "5", "3", "~"},     '{2'd3, "4", "4", "~"},
    '{2'd3, "4", "5", "~"},     '{2'd3, "5", "0", "~"},
    '{2'd3, "5", "1", "~"},     '{2'd3, "5", "2", "~"},
    '{2'd3, "5", "4", "~"},     '{2'd3, "5", "5", "~"}
  };

endpackage

/* design/console_key_sequence_decoder_top.sv */
// Console key sequence decoder: control bytes, CSI escape suffixes and plain characters.
// Pipeline: a request that is taken passes through two register stages, the input register
// and then the result register, before its result shows (result_valid_o high).
// Throughput: one request per cycle; busy is never raised, and the result strobe is
// a single cycle because the receiver cannot stall. The 46-entry suffix compare is
// the deepest logic and sits between the two registers.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload registers hold.
module console_key_sequence_decoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ckd_pkg::AVAIL_W-1:0]  bytes_available_i,
  input  logic [ckd_pkg::BYTE_W-1:0]   current_byte_i,
  input  logic [ckd_pkg::BYTE_W-1:0]   lookahead_one_i,
  input  logic [ckd_pkg::BYTE_W-1:0]   lookahead_two_i,
  input  logic [ckd_pkg::BYTE_W-1:0]   lookahead_three_i,
  output logic                         result_valid_o,
  output logic [ckd_pkg::KEY_W-1:0]    key_code_o,
  output logic [ckd_pkg::AVAIL_W-1:0]  bytes_consumed_o,
  output logic [ckd_pkg::BYTE_W-1:0]   char_value_o
);

  // Input register stage
  logic                        in_valid_q;
  logic [ckd_pkg::AVAIL_W-1:0] avail_q;
  logic [ckd_pkg::BYTE_W-1:0]  cur_q, la1_q, la2_q, la3_q;

  // Result register stage
  logic                        res_valid_q;
  logic [ckd_pkg::KEY_W-1:0]   key_q, key_d;
  logic [ckd_pkg::AVAIL_W-1:0] used_q, used_d;
  logic [ckd_pkg::BYTE_W-1:0]  chr_q, chr_d;

  logic [ckd_pkg::AVAIL_W-1:0] avail_clamped;
  logic [ckd_pkg::AVAIL_W-1:0] suffix_room;
  logic [ckd_pkg::SUFFIX_COUNT-1:0] hit;

  // Never stall: a new request enters every cycle.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      res_valid_q <= in_valid_q;
    end
  end

  // Capture the request payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      avail_q <= bytes_available_i;
      cur_q   <= current_byte_i;
      la1_q   <= lookahead_one_i;
      la2_q   <= lookahead_two_i;
      la3_q   <= lookahead_three_i;
    end
    if (in_valid_q) begin
      key_q  <= key_d;
      used_q <= used_d;
      chr_q  <= chr_d;
    end
  end

  // Clamp counts above four, then work out how many suffix bytes may be examined.
  assign avail_clamped = (avail_q > ckd_pkg::AVAIL_W'(ckd_pkg::MAX_AVAIL))
                         ? ckd_pkg::AVAIL_W'(ckd_pkg::MAX_AVAIL) : avail_q;
  assign suffix_room   = (avail_clamped == '0) ? '0 : avail_clamped - 3'd1;

  // Compare every table entry in parallel; only bytes within the entry length count.
  always_comb begin
    for (int i = 0; i < ckd_pkg::SUFFIX_COUNT; i++) begin
      hit[i] = ({1'b0, ckd_pkg::SUFFIX_TABLE[i].len} <= suffix_room)
            && (la1_q == ckd_pkg::SUFFIX_TABLE[i].b0)
            && ((ckd_pkg::SUFFIX_TABLE[i].len < 2'd2) || (la2_q == ckd_pkg::SUFFIX_TABLE[i].b1))
            && ((ckd_pkg::SUFFIX_TABLE[i].len < 2'd3) || (la3_q == ckd_pkg::SUFFIX_TABLE[i].b2));
    end
  end

  // Decode the current byte; the first table hit in table order wins.
  always_comb begin
    key_d  = ckd_pkg::KEY_DONE;
    used_d = '0;
    chr_d  = '0;
    if (avail_clamped != '0) begin
      used_d = 3'd1;
      case (cur_q)
        ckd_pkg::CHR_CTRL_C: key_d = ckd_pkg::KEY_CTRL_C;
        ckd_pkg::CHR_CTRL_D: key_d = ckd_pkg::KEY_CTRL_D;
        ckd_pkg::CHR_CTRL_E: key_d = ckd_pkg::KEY_CTRL_E;
        ckd_pkg::CHR_CTRL_F: key_d = ckd_pkg::KEY_CTRL_F;
        ckd_pkg::CHR_BS:     key_d = ckd_pkg::KEY_BACKSPACE;
        ckd_pkg::CHR_TAB:    key_d = ckd_pkg::KEY_TAB;
        ckd_pkg::CHR_LF:     key_d = ckd_pkg::KEY_LINEFEED;
        ckd_pkg::CHR_CR:     key_d = ckd_pkg::KEY_RETURN;
        ckd_pkg::CHR_DEL:    key_d = ckd_pkg::KEY_DELETE;
        ckd_pkg::CHR_CTRL_X: key_d = ckd_pkg::KEY_CONTROL_X;
        ckd_pkg::CSI_BYTE: begin
          key_d = ckd_pkg::KEY_UNKNOWN;
          // Walk from the back so the lowest matching entry lands last.
          for (int i = ckd_pkg::SUFFIX_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
              key_d  = ckd_pkg::KEY_TABLE_BASE + ckd_pkg::KEY_W'(i);
              used_d = 3'd1 + {1'b0, ckd_pkg::SUFFIX_TABLE[i].len};
            end
          end
        end
        default: begin
          key_d = ckd_pkg::KEY_STRING;
          chr_d = cur_q;
        end
      endcase
    end
  end

  assign result_valid_o   = res_valid_q;
  assign key_code_o       = key_q;
  assign bytes_consumed_o = used_q;
  assign char_value_o     = chr_q;

  // Every request yields exactly one result once it has passed the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 result_valid_o)
    else $error("result strobe missing two cycles after request");

  // A character is only reported with the string code.
  a_char_only_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (key_code_o != ckd_pkg::KEY_STRING)) |-> (char_value_o == '0))
    else $error("char_value nonzero for a non-string key");

  // Done consumes nothing; anything else consumes at least the current byte.
  a_done_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((key_code_o == ckd_pkg::KEY_DONE) == (bytes_consumed_o == '0)))
    else $error("bytes_consumed inconsistent with done code");

  // Table hits always consume the CSI plus at least one suffix byte.
  a_table_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (key_code_o >= ckd_pkg::KEY_TABLE_BASE))
      |-> ((bytes_consumed_o >= 3'd2) && (bytes_consumed_o <= 3'd4)))
    else $error("table key with bad consumed count");

endmodule
